@@ rtl/core/dtl_pkg.sv @@
`timescale 1ns / 1ps
// dtl_pkg: request codes, register indexes, FSM states and fixed field widths
// for the delayed table LFO. No dependencies.
package dtl_pkg;

    // fixed field widths
    localparam int REQ_W   = 3;
    localparam int TICK_W  = 13;
    localparam int PHASE_W = 32;
    localparam int DELAY_W = 24;
    localparam int FRAC_W  = 16;   // interpolation weight
    localparam int CFG_IDX_W = 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK      = 3'd0,
        REQ_TRIGGER   = 3'd1,
        REQ_SKIP      = 3'd2,
        REQ_PAUSE     = 3'd3,
        REQ_RESUME    = 3'd4,
        REQ_SET_PHASE = 3'd5,
        REQ_WRITE     = 3'd6
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP = 1'b0,
        CFG_DELAY_LEN  = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_ADV,
        ST_READ,
        ST_INTERP,
        ST_DONE
    } t_state;

endpackage

@@ rtl/core/delayed_table_lfo.sv @@
`timescale 1ns / 1ps
// delayed_table_lfo: table LFO with pre-delay, wave table in a two-read-port RAM.
// Depends on dtl_pkg.
//
// channel   dir  handshake                       payload
// --------  ---  ------------------------------  -------------------------------------
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser: req_type
//                                                tdata: tick_samples, phase_value,
//                                                       table_index, table_value
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: lfo_value
//                                                tuser: is_active, in_delay
// cfg       in   i_cfg_we (no wait)              i_cfg_idx, i_cfg_wdata
//
// Steps: one transfer in, one transfer out. Most requests go through accept with
// table read, interpolation multiply, result. A write-table request adds a read
// state, since the RAM read has to follow the write. A tick that gets past the
// delay runs the 13x32 phase increment multiply and the 32-bit phase add, each in
// its own state, ahead of the table read.
// Reset: synchronous, active low; clears state and config, not the wave table.
// Stalls: a finished result sits in the output register; the block takes the
// next request meanwhile and holds in the result state until the register frees.
module delayed_table_lfo
    import dtl_pkg::*;
#(
    parameter int IDX_BITS     = 8,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [PHASE_W-1:0]      i_cfg_wdata,
    // requests
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tick_samples, phase_value, table_index, table_value, zero pad (low bit up)
    input  logic [((TICK_W+PHASE_W+IDX_BITS+SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  logic [REQ_W-1:0]        s_axis_tuser,
    // results
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // lfo_value, zero pad
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // is_active, in_delay
    output logic [1:0]              m_axis_tuser
);

    localparam int SW         = SAMPLE_WIDTH;
    localparam int TABLE_SIZE = 1 << IDX_BITS;
    localparam int SUB_IDX_W  = PHASE_W - IDX_BITS;
    localparam int OUT_TD_W   = ((SW + 7) / 8) * 8;
    localparam int ACC_W      = SW + FRAC_W + 2;
    // input field offsets
    localparam int OFS_TICK   = 0;
    localparam int OFS_PHASE  = OFS_TICK + TICK_W;
    localparam int OFS_INDEX  = OFS_PHASE + PHASE_W;
    localparam int OFS_VALUE  = OFS_INDEX + IDX_BITS;
    localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (FRAC_W - 1);

    // input fields
    t_req                   w_req;
    logic [TICK_W-1:0]      w_samples;
    logic [PHASE_W-1:0]     w_phase_in;
    logic [IDX_BITS-1:0]    w_index_in;
    logic [SW-1:0]          w_value_in;

    assign w_req      = t_req'(s_axis_tuser);
    assign w_samples  = s_axis_tdata[OFS_TICK  +: TICK_W];
    assign w_phase_in = s_axis_tdata[OFS_PHASE +: PHASE_W];
    assign w_index_in = s_axis_tdata[OFS_INDEX +: IDX_BITS];
    assign w_value_in = s_axis_tdata[OFS_VALUE +: SW];

    // state
    t_state                 r_state, n_state;
    logic [PHASE_W-1:0]     r_phase_step;
    logic [DELAY_W-1:0]     r_delay_len;
    logic [PHASE_W-1:0]     r_phase;
    logic [DELAY_W-1:0]     r_delay_left;
    logic                   r_running;
    logic [SW-1:0]          r_held;
    logic [TICK_W-1:0]      r_left;       // samples left after the delay
    logic [PHASE_W-1:0]     r_prod;
    logic [SW-1:0]          r_v1;
    logic signed [ACC_W-1:0] r_mix;
    logic                   r_out_valid;
    logic [SW-1:0]          r_out_data;
    logic [1:0]             r_out_user;

    // wave table RAM, two registered read ports
    logic [SW-1:0]          mem [TABLE_SIZE];
    logic [SW-1:0]          r_rd1, r_rd2;
    logic [IDX_BITS-1:0]    w_rd_addr1, w_rd_addr2;

    // FSM outputs
    logic                   w_accept;
    logic                   w_use_next_phase;
    logic                   w_load_out;
    logic                   w_out_free;

    // datapath
    logic                   w_delay_outlasts;
    logic                   w_tick_adv;
    logic [PHASE_W-1:0]     w_next_phase;
    logic [PHASE_W-1:0]     w_rd_phase;
    logic [TICK_W+PHASE_W-1:0] w_prod_full;
    logic signed [SW:0]     w_diff;
    logic signed [FRAC_W:0] w_u;
    logic [ACC_W-1:0]       w_acc;
    logic [SW-1:0]          w_interp;
    logic                   w_in_delay;
    logic [SW-1:0]          w_result;

    assign w_accept   = s_axis_tvalid & s_axis_tready;
    assign w_out_free = ~r_out_valid | m_axis_tready;

    assign w_delay_outlasts = r_delay_left > {{(DELAY_W-TICK_W){1'b0}}, w_samples};
    assign w_tick_adv = (w_req == REQ_TICK) && r_running && !w_delay_outlasts;

    // phase as it stands after a request that changes it directly
    always_comb begin
        unique case (w_req)
            REQ_TRIGGER:   w_next_phase = '0;
            REQ_SET_PHASE: w_next_phase = w_phase_in;
            default:       w_next_phase = r_phase;
        endcase
    end

    assign w_rd_phase = w_use_next_phase ? w_next_phase : r_phase;
    assign w_rd_addr1 = w_rd_phase[PHASE_W-1 -: IDX_BITS];
    assign w_rd_addr2 = w_rd_addr1 + IDX_BITS'(1);   // wraps around the table

    always_ff @(posedge i_clk) begin
        if (w_accept && w_req == REQ_WRITE) begin
            mem[w_index_in] <= w_value_in;
        end
        r_rd1 <= mem[w_rd_addr1];
        r_rd2 <= mem[w_rd_addr2];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (w_tick_adv)
                        n_state = ST_STEP;
                    else if (w_req == REQ_WRITE)
                        n_state = ST_READ;   // read after the write lands
                    else
                        n_state = ST_INTERP;
                end
            end
            ST_STEP:   n_state = ST_ADV;
            ST_ADV:    n_state = ST_READ;
            ST_READ:   n_state = ST_INTERP;
            ST_INTERP: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free)
                    n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_axis_tready    = 1'b0;
        w_use_next_phase = 1'b0;
        w_load_out       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready    = 1'b1;
                w_use_next_phase = 1'b1;
            end
            ST_DONE:  w_load_out = w_out_free;
            default: ;
        endcase
    end

    // 13x32 phase increment, low word kept
    assign w_prod_full = r_left * r_phase_step;

    // interpolation: v1*2^16 + (v2-v1)*u, rounded, floor shift
    assign w_diff = $signed({r_rd2[SW-1], r_rd2}) - $signed({r_rd1[SW-1], r_rd1});
    assign w_u    = $signed({1'b0, r_phase[SUB_IDX_W-1 -: FRAC_W]});
    assign w_acc  = {{2{r_v1[SW-1]}}, r_v1, {FRAC_W{1'b0}}} + r_mix + ROUND;
    assign w_interp = w_acc[SW+FRAC_W-1:FRAC_W];

    assign w_in_delay = (r_delay_left != '0);
    always_comb begin
        if (w_in_delay)
            w_result = '0;
        else if (r_running)
            w_result = w_interp;
        else
            w_result = r_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase_step <= '0;
            r_delay_len  <= '0;
            r_phase      <= '0;
            r_delay_left <= '0;
            r_running    <= 1'b0;
            r_held       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_PHASE_STEP: r_phase_step <= i_cfg_wdata;
                    CFG_DELAY_LEN:  r_delay_len  <= i_cfg_wdata[DELAY_W-1:0];
                    default: ;
                endcase
            end

            if (w_accept) begin
                unique case (w_req)
                    REQ_TICK: begin
                        if (r_running) begin
                            if (w_delay_outlasts) begin
                                r_delay_left <= r_delay_left
                                              - {{(DELAY_W-TICK_W){1'b0}}, w_samples};
                            end else begin
                                r_left       <= w_samples - r_delay_left[TICK_W-1:0];
                                r_delay_left <= '0;
                            end
                        end
                    end
                    REQ_TRIGGER: begin
                        r_delay_left <= r_delay_len;
                        r_phase      <= '0;
                        r_held       <= '0;
                        r_running    <= 1'b1;
                    end
                    REQ_SKIP:      r_delay_left <= '0;
                    REQ_PAUSE:     r_running    <= 1'b0;
                    REQ_RESUME:    r_running    <= 1'b1;
                    REQ_SET_PHASE: r_phase      <= w_phase_in;
                    default: ;     // table write handled at the RAM; code 7 is a no-op
                endcase
            end

            if (r_state == ST_STEP)
                r_prod <= w_prod_full[PHASE_W-1:0];
            if (r_state == ST_ADV)
                r_phase <= r_phase + r_prod;

            if (r_state == ST_INTERP) begin
                r_v1  <= r_rd1;
                r_mix <= w_diff * w_u;
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
                r_out_data  <= w_result;
                r_out_user  <= {w_in_delay, r_running};
                if (!w_in_delay && r_running)
                    r_held <= w_interp;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TD_W-SW){1'b0}}, r_out_data};
    assign m_axis_tuser  = r_out_user;

    // a trigger restarts the phase, clears the held value and runs
    a_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_req == REQ_TRIGGER)
            |=> (r_phase == '0 && r_held == '0 && r_running))
        else $error("trigger did not restart the oscillator");

    // while the delay runs the output reads zero
    a_delay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user[1]) |-> (r_out_data == '0))
        else $error("nonzero output during pre-delay");

    // a finished result waits in DONE while the output register is blocked
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !m_axis_tready) |=> (r_state == ST_DONE))
        else $error("result left DONE while output was stalled");

    // no request is taken while one is in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("request accepted back to back");

endmodule
